### rtl/core/cds_pkg.sv
// Package for the cone direction sampler: formats, constants and tables.
package cds_pkg;

   localparam int RandBitsDefault    = 32;
   localparam int CordicStepsDefault = 30;
   localparam int TableLen           = 40;

   localparam logic [31:0] CsrResetValue = 32'd9985763;
   localparam logic [31:0] SmaxLimit     = 32'h8000_0000;
   localparam logic signed [33:0] OneQ30    = 34'sd1073741824;
   localparam logic signed [33:0] GainQ30   = 34'sd652032874;

   typedef logic signed [33:0] cordic_word_type;

   // atan(2^-i) in turns, Q0.32
   function automatic logic [31:0] atan_turns(input int idx);
      logic [31:0] tbl [TableLen];
      tbl = '{32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
              32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
              32'd2670163, 32'd1335087, 32'd667544, 32'd333772, 32'd166886,
              32'd83443, 32'd41722, 32'd20861, 32'd10430, 32'd5215, 32'd2608,
              32'd1304, 32'd652, 32'd326, 32'd163, 32'd81, 32'd41, 32'd20,
              32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0, 32'd0, 32'd0, 32'd0,
              32'd0, 32'd0, 32'd0, 32'd0, 32'd0};
      return tbl[idx];
   endfunction

   function automatic logic signed [33:0] clamp_q30(input logic signed [33:0] v);
      if (v > OneQ30) return OneQ30;
      if (v < -OneQ30) return -OneQ30;
      return v;
   endfunction

   // Pipeline stage flow control
   typedef struct packed {
      logic valid;
      logic ready;
   } flow_type;

endpackage

### rtl/core/cds_sqrt.sv
// Pipelined restoring integer square root, two result bits per stage.
module cds_sqrt
   import cds_pkg::*;
#(
   parameter int OUT_BITS = 32,
   parameter int TAG_BITS = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic                    in_valid,
   input  logic [2*OUT_BITS-1:0]   in_radicand,
   input  logic [TAG_BITS-1:0]     in_tag,
   output logic                    out_valid,
   output logic [OUT_BITS-1:0]     out_root,
   output logic [TAG_BITS-1:0]     out_tag
);
   localparam int Stages = (OUT_BITS + 1) / 2;
   localparam int W      = 2 * OUT_BITS;

   logic [W-1:0]        rem_ff  [Stages+1];
   logic [W-1:0]        num_ff  [Stages+1];
   logic [OUT_BITS-1:0] root_ff [Stages+1];
   logic [TAG_BITS-1:0] tag_ff  [Stages+1];
   logic                vld_ff  [Stages+1];

   always_comb begin
      rem_ff[0]  = '0;
      num_ff[0]  = in_radicand;
      root_ff[0] = '0;
      tag_ff[0]  = in_tag;
      vld_ff[0]  = in_valid;
   end

   for (genvar g = 0; g < Stages; g++) begin : g_stage
      logic [W-1:0]        rem_in, num_in;
      logic [OUT_BITS-1:0] root_in;
      logic [W+1:0]        acc, trial;
      logic [W-1:0]        rem_s, num_s;
      logic [OUT_BITS-1:0] root_s;
      logic [OUT_BITS-1:0] rq;
      logic [W+1:0]        rq_w;
      always_comb begin
         rem_s  = rem_ff[g];
         num_s  = num_ff[g];
         root_s = root_ff[g];
         for (int k = 0; k < 2; k++) begin
            acc   = {rem_s, num_s[W-1 -: 2]};
            rq    = root_s;
            rq_w  = {{(W+2-OUT_BITS){1'b0}}, rq};
            trial = (rq_w << 2) | {{(W+1){1'b0}}, 1'b1};
            num_s = num_s << 2;
            if (acc >= trial) begin
               rem_s  = W'(acc - trial);
               root_s = {root_s[OUT_BITS-2:0], 1'b1};
            end else begin
               rem_s  = W'(acc);
               root_s = {root_s[OUT_BITS-2:0], 1'b0};
            end
         end
         rem_in  = rem_s;
         num_in  = num_s;
         root_in = root_s;
      end
      logic [W-1:0]        rem_r, num_r;
      logic [OUT_BITS-1:0] root_r;
      logic [TAG_BITS-1:0] tag_r;
      logic                vld_r;
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_r <= 1'b0;
         end else if (advance) begin
            vld_r <= vld_ff[g];
         end
         if (advance) begin
            rem_r  <= rem_in;
            num_r  <= num_in;
            root_r <= root_in;
            tag_r  <= tag_ff[g];
         end
      end
      always_comb begin
         rem_ff[g+1]  = rem_r;
         num_ff[g+1]  = num_r;
         root_ff[g+1] = root_r;
         tag_ff[g+1]  = tag_r;
         vld_ff[g+1]  = vld_r;
      end
   end

   assign out_valid = vld_ff[Stages];
   assign out_root  = root_ff[Stages];
   assign out_tag   = tag_ff[Stages];
endmodule

### rtl/core/cds_cordic.sv
// Pipelined rotation CORDIC giving sin and cos of a quarter-turn residual.
module cds_cordic
   import cds_pkg::*;
#(
   parameter int CORDIC_STEPS = CordicStepsDefault,
   parameter int DEPTH        = 16
) (
   input  logic                   clock,
   input  logic                   advance,
   input  logic [29:0]            in_angle,
   output logic signed [33:0]     out_cos,
   output logic signed [33:0]     out_sin
);
   // steps per register stage, spread over DEPTH stages
   localparam int Per = (CORDIC_STEPS + DEPTH - 1) / DEPTH;

   cordic_word_type x_ff [DEPTH+1];
   cordic_word_type y_ff [DEPTH+1];
   logic signed [33:0] z_ff [DEPTH+1];

   always_comb begin
      x_ff[0] = GainQ30;
      y_ff[0] = '0;
      z_ff[0] = $signed({4'd0, in_angle});
   end

   for (genvar g = 0; g < DEPTH; g++) begin : g_stage
      cordic_word_type x_s, y_s, nx;
      logic signed [33:0] z_s;
      always_comb begin
         x_s = x_ff[g];
         y_s = y_ff[g];
         z_s = z_ff[g];
         for (int k = 0; k < Per; k++) begin
            if (g * Per + k < CORDIC_STEPS && g * Per + k < TableLen) begin
               if (z_s >= 0) begin
                  nx  = x_s - (y_s >>> (g * Per + k));
                  y_s = y_s + (x_s >>> (g * Per + k));
                  z_s = z_s - $signed({2'd0, atan_turns(g * Per + k)});
               end else begin
                  nx  = x_s + (y_s >>> (g * Per + k));
                  y_s = y_s - (x_s >>> (g * Per + k));
                  z_s = z_s + $signed({2'd0, atan_turns(g * Per + k)});
               end
               x_s = nx;
            end else begin
               nx = x_s;
            end
         end
      end
      cordic_word_type x_r, y_r;
      logic signed [33:0] z_r;
      always_ff @(posedge clock) begin
         if (advance) begin
            x_r <= x_s;
            y_r <= y_s;
            z_r <= z_s;
         end
      end
      always_comb begin
         x_ff[g+1] = x_r;
         y_ff[g+1] = y_r;
         z_ff[g+1] = z_r;
      end
   end

   assign out_cos = x_ff[DEPTH];
   assign out_sin = y_ff[DEPTH];
endmodule

### rtl/core/cone_direction_sampler_top.sv
// Top level of the cone direction sampler pipeline.
// Cone direction sampler: each input word (u_phi, u_radius) yields one unit
// direction word inside the cone set by csr sin_cone_half_angle (Q0.31).
// Throughput is one word per clock while the skid register is empty. The path
// is the r square root (16 stages, two root bits per stage), the s multiply,
// the s rounding and trig select, the s*s square, the cos(theta) square root
// (16 stages) and the output register. The CORDIC runs alongside the first
// root in 16 stages, and the scale multiplies run alongside the second.
// A result that arrives while the output word waits with rsp_tready low parks
// in the skid register. From then on the whole pipeline and req_tready hold
// until the skid drains. The skid keeps req_tready free of any combinational
// path from rsp_tready.
module cone_direction_sampler_top
   import cds_pkg::*;
#(
   parameter int RAND_BITS    = RandBitsDefault,
   parameter int CORDIC_STEPS = CordicStepsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // u_phi[31:0], u_radius[63:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // dir_x[31:0], dir_y[62:32], dir_z[94:63], zero
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data
);
   localparam int Drop = (RAND_BITS >= 32) ? 0 : 32 - RAND_BITS;
   localparam logic [31:0] KeepMask = 32'hFFFF_FFFF << Drop;

   logic [31:0] smax_ff;
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         smax_ff <= CsrResetValue;
      end else if (csr_valid) begin
         smax_ff <= csr_data;
      end
   end

   // pipeline advances whenever the skid register is empty
   logic out_vld_ff, skid_vld_ff, advance;
   logic [95:0] out_data_ff, skid_data_ff;
   assign advance    = !skid_vld_ff;
   assign req_tready = advance;
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;

   logic [31:0] uphi, urad;
   assign uphi = req_tdata[31:0] & KeepMask;
   assign urad = req_tdata[63:32] & KeepMask;

   // stage A: r = isqrt(urad << 32); quadrant travels as tag
   logic        ra_vld;
   logic [31:0] r_root;
   logic [1:0]  ra_quad;
   cds_sqrt #(.OUT_BITS(32), .TAG_BITS(2)) u_sqrt_r (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(req_tvalid && req_tready),
      .in_radicand({urad, 32'd0}), .in_tag(uphi[31:30]),
      .out_valid(ra_vld), .out_root(r_root), .out_tag(ra_quad));

   logic signed [33:0] cos_c, sin_c;
   cds_cordic #(.CORDIC_STEPS(CORDIC_STEPS), .DEPTH(16)) u_cordic (
      .clock(clock), .advance(advance), .in_angle(uphi[29:0]),
      .out_cos(cos_c), .out_sin(sin_c));

   // stage B: s = smax*r rounded, clamped
   logic [31:0] smax_c;
   assign smax_c = (smax_ff > SmaxLimit) ? SmaxLimit : smax_ff;
   logic        b_vld_ff;
   logic [63:0] b_prod_ff;
   logic [1:0]  b_quad_ff;
   logic signed [33:0] b_cos_ff, b_sin_ff;
   always_ff @(posedge clock) begin
      if (reset) b_vld_ff <= 1'b0;
      else if (advance) b_vld_ff <= ra_vld;
      if (advance) begin
         b_prod_ff <= smax_c * r_root;
         b_quad_ff <= ra_quad;
         b_cos_ff  <= clamp_q30(cos_c);
         b_sin_ff  <= clamp_q30(sin_c);
      end
   end
   logic [64:0] s_sum;
   logic [31:0] s_in;
   assign s_sum = {1'b0, b_prod_ff} + 65'h1_0000_0000;
   assign s_in  = (s_sum[64:33] > 32'h4000_0000) ? 32'h4000_0000 : s_sum[64:33];

   // stage C: round s, select trig by quadrant
   logic        c_vld_ff;
   logic [30:0] c_s_ff;
   logic signed [33:0] c_sinp_ff, c_cosp_ff;
   logic signed [33:0] sinp_in, cosp_in;
   always_comb begin
      unique case (b_quad_ff)
         2'd0: begin sinp_in = b_sin_ff;  cosp_in = b_cos_ff;  end
         2'd1: begin sinp_in = b_cos_ff;  cosp_in = -b_sin_ff; end
         2'd2: begin sinp_in = -b_sin_ff; cosp_in = -b_cos_ff; end
         default: begin sinp_in = -b_cos_ff; cosp_in = b_sin_ff; end
      endcase
   end
   always_ff @(posedge clock) begin
      if (reset) c_vld_ff <= 1'b0;
      else if (advance) c_vld_ff <= b_vld_ff;
      if (advance) begin
         c_s_ff    <= s_in[30:0];
         c_sinp_ff <= sinp_in;
         c_cosp_ff <= cosp_in;
      end
   end

   // stage E: square s for the cos(theta) radicand
   logic        e_vld_ff;
   logic [60:0] e_ss_ff;
   always_ff @(posedge clock) begin
      if (reset) e_vld_ff <= 1'b0;
      else if (advance) e_vld_ff <= c_vld_ff;
      if (advance) begin
         e_ss_ff <= c_s_ff * c_s_ff;
      end
   end

   // stage D: cos(theta) sqrt runs alongside the two scale multiplies
   logic [63:0] d_rad;
   assign d_rad = {3'd0, 61'h1000_0000_0000_0000 - e_ss_ff};
   logic        d_vld;
   logic [31:0] c_root;
   logic [0:0]  d_unused;
   cds_sqrt #(.OUT_BITS(32), .TAG_BITS(1)) u_sqrt_c (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(e_vld_ff), .in_radicand(d_rad), .in_tag(1'b0),
      .out_valid(d_vld), .out_root(c_root), .out_tag(d_unused));

   // scale products delayed to match the 16-stage root
   localparam int Dly = 16;
   logic [31:0] mx_ff [Dly];
   logic [31:0] mz_ff [Dly];
   logic [62:0] px, pz;
   logic [31:0] ax, az;
   logic [30:0] mag_x, mag_z;
   assign mag_x = c_sinp_ff[33] ? 31'(-c_sinp_ff) : c_sinp_ff[30:0];
   assign mag_z = c_cosp_ff[33] ? 31'(-c_cosp_ff) : c_cosp_ff[30:0];
   logic [61:0] pxm_ff, pzm_ff;
   logic        nx_ff, nz_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         pxm_ff <= c_s_ff * mag_x;
         pzm_ff <= c_s_ff * mag_z;
         nx_ff  <= c_sinp_ff[33];
         nz_ff  <= c_cosp_ff[33];
      end
   end
   assign px = {1'b0, pxm_ff} + 63'h2000_0000;
   assign pz = {1'b0, pzm_ff} + 63'h2000_0000;
   assign ax = (px[62:30] > 33'h4000_0000) ? 32'h4000_0000 : px[61:30];
   assign az = (pz[62:30] > 33'h4000_0000) ? 32'h4000_0000 : pz[61:30];
   always_ff @(posedge clock) begin
      if (advance) begin
         mx_ff[0] <= nx_ff ? -ax : ax;
         mz_ff[0] <= nz_ff ? -az : az;
         for (int k = 1; k < Dly; k++) begin
            mx_ff[k] <= mx_ff[k-1];
            mz_ff[k] <= mz_ff[k-1];
         end
      end
   end
   // the root output lines up with the last product delay register
   logic [30:0] y_val;
   assign y_val = 31'(-{1'b0, c_root[30:0]});
   logic [95:0] res_word;
   assign res_word = {1'b0, mz_ff[Dly-1], y_val, mx_ff[Dly-1]};

   // output register with skid
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         if (!out_vld_ff || rsp_tready) begin
            if (skid_vld_ff) begin
               out_vld_ff  <= 1'b1;
               skid_vld_ff <= 1'b0;
            end else begin
               out_vld_ff <= d_vld && advance;
            end
         end else if (d_vld && advance) begin
            skid_vld_ff <= 1'b1;
         end
      end
      if (!out_vld_ff || rsp_tready) begin
         out_data_ff <= skid_vld_ff ? skid_data_ff : res_word;
      end else if (d_vld && advance) begin
         skid_data_ff <= res_word;
      end
   end

   a_skid_only_when_full: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff) else $error("skid filled with empty output");
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && !rsp_tready && skid_vld_ff) |=> skid_vld_ff)
      else $error("skid word lost");
   a_y_nonpos: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[62] || rsp_tdata[62:32] == 31'd0))
      else $error("dir_y positive");
endmodule

### tb/tb_cone_direction_sampler_top.sv
// Testbench for the cone direction sampler: directed and random words checked against a predictor.
`timescale 1ns / 100ps

module tb_cone_direction_sampler_top;
   import cds_pkg::*;

   localparam int LatencyCycles = 35;
   localparam int WatchdogLimit = 4000;
   localparam int NumRandom     = 576;

   typedef struct {
      logic signed [31:0] dir_x;
      logic signed [30:0] dir_y;
      logic signed [31:0] dir_z;
   } direction_type;

   typedef struct {
      logic [31:0]   u_phi;
      logic [31:0]   u_radius;
      logic          known;     // expected result typed in below
      direction_type dir;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [95:0] rsp_tdata;
   logic        csr_valid;
   logic        csr_ready;
   logic [31:0] csr_data;

   cone_direction_sampler_top u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   logic [31:0]   cone_sine;
   direction_type expected_dirs[$];
   int            mismatch_count;
   int            idle_cycles;
   bit            sink_idle_on;
   bit            timed_out;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [63:0] int_sqrt(input logic [63:0] n);
      logic [63:0] res;
      logic [63:0] bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n   = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic longint sat_unit(input longint v);
      if (v > 64'sd1073741824) return 64'sd1073741824;
      if (v < -64'sd1073741824) return -64'sd1073741824;
      return v;
   endfunction

   function automatic longint scale_round(input longint s, input longint t);
      longint mag;
      longint p;
      mag = (t < 0) ? -t : t;
      p   = (s * mag + (64'sd1 << 29)) >>> 30;
      return sat_unit((t < 0) ? -p : p);
   endfunction

   function automatic direction_type predict_direction(input logic [31:0] u_phi,
                                                       input logic [31:0] u_radius);
      direction_type d;
      logic [63:0] smax;
      logic [63:0] r;
      logic [63:0] s;
      logic [63:0] c;
      longint x, y, z, nx, sn, cs, sin_phi, cos_phi;
      logic [1:0] quad;
      smax = cone_sine;
      if (smax > (64'd1 << 31)) smax = 64'd1 << 31;
      r = int_sqrt({u_radius, 32'd0});
      s = (smax * r + (64'd1 << 32)) >> 33;
      if (s > 64'd1073741824) s = 64'd1073741824;
      c = int_sqrt((64'd1 << 60) - s * s);
      quad = u_phi[31:30];
      z = longint'(u_phi[29:0]);
      x = 64'sd652032874;
      y = 0;
      for (int i = 0; i < CordicStepsDefault && i < TableLen; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            z  = z - longint'(atan_turns(i));
         end else begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            z  = z + longint'(atan_turns(i));
         end
         x = nx;
      end
      cs = sat_unit(x);
      sn = sat_unit(y);
      case (quad)
         2'd0: begin sin_phi = sn;  cos_phi = cs;  end
         2'd1: begin sin_phi = cs;  cos_phi = -sn; end
         2'd2: begin sin_phi = -sn; cos_phi = -cs; end
         default: begin sin_phi = -cs; cos_phi = sn; end
      endcase
      d.dir_x = 32'(scale_round(longint'(s), sin_phi));
      d.dir_y = 31'(-longint'(c));
      d.dir_z = 32'(scale_round(longint'(s), cos_phi));
      return d;
   endfunction

   // Sink side: random stall bursts, then none in the closing part.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready  <= 1'b0;
         idle_cycles <= 0;
      end else if (!sink_idle_on) begin
         rsp_tready <= 1'b1;
      end else if (idle_cycles > 0) begin
         idle_cycles <= idle_cycles - 1;
         rsp_tready  <= (idle_cycles == 1);
      end else if ($urandom_range(0, 5) == 0) begin
         idle_cycles <= $urandom_range(1, 16);
         rsp_tready  <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      direction_type got;
      direction_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.dir_x = rsp_tdata[31:0];
         got.dir_y = rsp_tdata[62:32];
         got.dir_z = rsp_tdata[94:63];
         if (expected_dirs.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected direction word x=%0d y=%0d z=%0d",
                        got.dir_x, got.dir_y, got.dir_z);
         end else begin
            want = expected_dirs.pop_front();
            if (got.dir_x !== want.dir_x || got.dir_y !== want.dir_y
                || got.dir_z !== want.dir_z) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("direction differs: want x=%0d y=%0d z=%0d got x=%0d y=%0d z=%0d",
                           want.dir_x, want.dir_y, want.dir_z,
                           got.dir_x, got.dir_y, got.dir_z);
            end
         end
      end
   end

   // Watchdog: count cycles with no word accepted on any channel.
   int stuck_cycles;
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
         if (stuck_cycles >= WatchdogLimit && !timed_out) begin
            timed_out = 1'b1;
            $display("cone_direction_sampler_top: mismatch");
            $finish;
         end
      end
   end

   task automatic write_cone_sine(input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cone_sine = value;
   endtask

   task automatic drain_results();
      while (expected_dirs.size() != 0) @(posedge clock);
      repeat (LatencyCycles) @(posedge clock);
   endtask

   // Hold valid across back-to-back words; lower it only for an idle burst.
   task automatic send_word(input logic [31:0] u_phi, input logic [31:0] u_radius,
                            input bit allow_idle);
      int gap;
      gap = (allow_idle && $urandom_range(0, 5) == 0) ? $urandom_range(1, 16) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {u_radius, u_phi};
      expected_dirs.push_back(predict_direction(u_phi, u_radius));
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_directed();
      stim_row_type rows[$];
      direction_type zero_dir;
      zero_dir.dir_x = 0;
      zero_dir.dir_y = -31'sd1073741824;
      zero_dir.dir_z = 0;
      // zero radius gives s = 0: straight down the axis
      rows.push_back('{32'h0000_0000, 32'h0000_0000, 1'b1, zero_dir});
      rows.push_back('{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, zero_dir});
      rows.push_back('{32'h4000_0000, 32'h0000_0000, 1'b1, zero_dir});
      rows.push_back('{32'h0000_0000, 32'hFFFF_FFFF, 1'b0, zero_dir});
      rows.push_back('{32'h4000_0000, 32'hFFFF_FFFF, 1'b0, zero_dir});
      rows.push_back('{32'h8000_0000, 32'hFFFF_FFFF, 1'b0, zero_dir});
      rows.push_back('{32'hC000_0000, 32'hFFFF_FFFF, 1'b0, zero_dir});
      rows.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, zero_dir});
      rows.push_back('{32'h3FFF_FFFF, 32'h4000_0000, 1'b0, zero_dir});
      rows.push_back('{32'h2000_0000, 32'h0000_0001, 1'b0, zero_dir});
      rows.push_back('{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, zero_dir});
      rows.push_back('{32'h5555_5555, 32'hAAAA_AAAA, 1'b0, zero_dir});
      foreach (rows[i]) begin
         send_word(rows[i].u_phi, rows[i].u_radius, 1'b0);
         if (rows[i].known) begin
            void'(expected_dirs.pop_back());
            expected_dirs.push_back(rows[i].dir);
         end
      end
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_random(input int count, input bit allow_idle);
      logic [31:0] u_phi;
      logic [31:0] u_radius;
      for (int n = 0; n < count; n++) begin
         u_phi    = $urandom;
         u_radius = $urandom;
         case ($urandom_range(0, 7))
            0: u_radius = $urandom_range(0, 255);
            1: u_radius = ~($urandom_range(0, 255));
            2: u_phi = {u_phi[31:30], 30'd0} + $urandom_range(0, 3);
            default: ;
         endcase
         send_word(u_phi, u_radius, allow_idle);
         // sender hold-off until everything has drained
         if (n == count / 2) begin
            req_tvalid <= 1'b0;
            while (expected_dirs.size() != 0) @(posedge clock);
         end
      end
      req_tvalid <= 1'b0;
   endtask

   initial begin
      logic [31:0] cone_settings[5];
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      csr_valid      = 1'b0;
      csr_data       = '0;
      mismatch_count = 0;
      timed_out      = 1'b0;
      sink_idle_on   = 1'b1;
      cone_sine      = CsrResetValue;
      cone_settings  = '{SmaxLimit, 32'd0, 32'hFFFF_FFFF, 32'h5A82_7999, 32'd9985763};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset value of the cone sine first
      send_directed();
      drain_results();
      foreach (cone_settings[k]) begin
         write_cone_sine(cone_settings[k]);
         send_directed();
         send_random(NumRandom / 6, 1'b1);
         drain_results();
      end
      write_cone_sine($urandom);
      sink_idle_on = 1'b0;
      send_random(NumRandom / 6, 1'b0);
      drain_results();

      if (mismatch_count == 0 && expected_dirs.size() == 0) begin
         $display("cone_direction_sampler_top: match");
      end else begin
         $display("cone_direction_sampler_top: mismatch");
      end
      $finish;
   end

endmodule
